// ===== rtl/sli_pkg.sv =====
// Shared types and constants for the sorted list store.
`default_nettype none

package sli_pkg;

    // Default number of list entries
    localparam int SLI_DEPTH = 16;

    // Payload widths
    localparam int SLI_VAL_W = 32;
    localparam int SLI_CNT_OUT_W = 5;

    // Input action codes (code 3 is unused)
    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_DUMP   = 2'd2
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_EMPTY     = 2'd3
    } t_status;

    // Operation broadcast to every cell of the chain
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_ROTATE = 2'd3
    } t_op;

    typedef struct packed {
        t_op                          op;
        logic signed [SLI_VAL_W-1:0] value;
    } t_ctrl;

    // Control sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_DUMP = 1'b1
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/sli_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
`default_nettype none

interface sli_req_if import sli_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic signed [SLI_VAL_W-1:0]  value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface sli_rsp_if import sli_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic signed [SLI_VAL_W-1:0]     entry_value;
    logic [SLI_CNT_OUT_W-1:0]        entry_count;
    logic                            last;

    modport source (output valid, output status, output entry_value,
                    output entry_count, output last, input ready);
    modport sink   (input valid, input status, input entry_value,
                    input entry_count, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/sli_cell.sv =====
// One list cell: holds an entry and shifts it with its neighbors.
`default_nettype none

module sli_cell import sli_pkg::*; (
    input  wire logic                        i_clk,
    input  wire t_ctrl                       i_ctrl,
    input  wire logic                        i_in_range,
    input  wire logic                        i_is_tail,
    input  wire logic signed [SLI_VAL_W-1:0] i_left_val,
    input  wire logic                        i_left_pos,
    input  wire logic signed [SLI_VAL_W-1:0] i_right_val,
    input  wire logic signed [SLI_VAL_W-1:0] i_head_val,
    input  wire logic                        i_found_left,
    output logic signed [SLI_VAL_W-1:0]      o_val,
    output logic                             o_pos,
    output logic                             o_found
);

    logic signed [SLI_VAL_W-1:0] r_val;
    logic signed [SLI_VAL_W-1:0] n_val;
    logic                        w_gt;
    logic                        w_eq;

    // Insert point is at or before this cell; sorted order keeps it monotone
    assign w_gt    = i_in_range && (r_val > i_ctrl.value);
    assign o_pos   = w_gt || !i_in_range;

    // First match of a delete ripples to the right
    assign w_eq    = i_in_range && (r_val == i_ctrl.value);
    assign o_found = i_found_left || w_eq;

    assign o_val   = r_val;

    // Next entry
    always_comb begin
        n_val = r_val;
        case (i_ctrl.op)
            OP_INSERT: begin
                if (i_left_pos) begin
                    n_val = i_left_val;
                end else if (o_pos) begin
                    n_val = i_ctrl.value;
                end
            end
            OP_DELETE: begin
                if (o_found) begin
                    n_val = i_right_val;
                end
            end
            OP_ROTATE: begin
                if (i_is_tail) begin
                    n_val = i_head_val;
                end else if (i_in_range) begin
                    n_val = i_right_val;
                end
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

// ===== rtl/sli_chain.sv =====
// Row of list cells with the range and tail flags derived from the count.
`default_nettype none

module sli_chain import sli_pkg::*; #(
    parameter int DEPTH = SLI_DEPTH,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  wire logic                   i_clk,
    input  wire t_ctrl                  i_ctrl,
    input  wire logic [CW-1:0]          i_count,
    output logic signed [SLI_VAL_W-1:0] o_head,
    output logic                        o_found
);

    logic signed [SLI_VAL_W-1:0] w_val   [DEPTH];
    logic                        w_pos   [DEPTH];
    logic                        w_found [DEPTH];

    assign o_head  = w_val[0];
    assign o_found = w_found[DEPTH-1];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [SLI_VAL_W-1:0] w_left_val;
        logic                        w_left_pos;
        logic signed [SLI_VAL_W-1:0] w_right_val;
        logic                        w_found_left;
        logic                        w_in_range;
        logic                        w_is_tail;

        // Neighbor hookup; the ends see neutral values
        if (g == 0) begin : g_first
            assign w_left_val   = '0;
            assign w_left_pos   = 1'b0;
            assign w_found_left = 1'b0;
        end else begin : g_mid
            assign w_left_val   = w_val[g-1];
            assign w_left_pos   = w_pos[g-1];
            assign w_found_left = w_found[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right_val = w_val[g];
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
        end

        assign w_in_range = CW'(g) < i_count;
        assign w_is_tail  = CW'(g + 1) == i_count;

        sli_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_in_range   (w_in_range),
            .i_is_tail    (w_is_tail),
            .i_left_val   (w_left_val),
            .i_left_pos   (w_left_pos),
            .i_right_val  (w_right_val),
            .i_head_val   (w_val[0]),
            .i_found_left (w_found_left),
            .o_val        (w_val[g]),
            .o_pos        (w_pos[g]),
            .o_found      (w_found[g])
        );
    end

endmodule

`default_nettype wire

// ===== rtl/sorted_list_insert_delete.sv =====
// Sorted list store: insert, delete and in-order dump over a chain of cells.
// Insert or delete: the cell row updates as the request is taken and the result is registered;
// the next request is taken once the output register is free. Dump: the request is taken, then
// each entry in turn, as the row rotates by one cell; the next request is taken as the last entry transfers out.
// An output register decouples the result stream; its stall holds the sequencer.
// Reset (synchronous, active low) clears the entry count, sequencer and result valid.
`default_nettype none

module sorted_list_insert_delete import sli_pkg::*; #(
    parameter int DEPTH = SLI_DEPTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sli_req_if.sink    i_req,
    sli_rsp_if.source  o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_dump_left, n_dump_left;
    logic                        r_out_valid, n_out_valid;
    t_status                     r_status, n_status;
    logic signed [SLI_VAL_W-1:0] r_entry, n_entry;
    logic [SLI_CNT_OUT_W-1:0]    r_cnt_out, n_cnt_out;
    logic                        r_last, n_last;

    t_ctrl                       w_ctrl;
    logic signed [SLI_VAL_W-1:0] w_head;
    logic                        w_found;
    logic                        w_out_free;
    logic                        w_accept;
    logic [CW+SLI_CNT_OUT_W-1:0] w_cnt_ext;

    // Cell row
    sli_chain #(.DEPTH(DEPTH)) u_chain (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_count (r_count),
        .o_head  (w_head),
        .o_found (w_found)
    );

    // Handshake
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;

    // Count as reported, masked to the field width
    assign w_cnt_ext = {{SLI_CNT_OUT_W{1'b0}}, n_count};

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_dump_left  = r_dump_left;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_status     = r_status;
        n_entry      = r_entry;
        n_last       = r_last;
        w_ctrl.op    = OP_HOLD;
        w_ctrl.value = i_req.value;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_action'(i_req.action))
                        ACT_INSERT: begin
                            n_out_valid = 1'b1;
                            n_entry     = '0;
                            n_last      = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                n_status = STS_FULL;
                            end else begin
                                w_ctrl.op = OP_INSERT;
                                n_count   = r_count + 1'b1;
                                n_status  = STS_OK;
                            end
                        end
                        ACT_DELETE: begin
                            n_out_valid = 1'b1;
                            n_entry     = '0;
                            n_last      = 1'b1;
                            w_ctrl.op   = OP_DELETE;
                            if (w_found) begin
                                n_count  = r_count - 1'b1;
                                n_status = STS_OK;
                            end else begin
                                n_status = STS_NOT_FOUND;
                            end
                        end
                        ACT_DUMP: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_entry     = '0;
                                n_last      = 1'b1;
                                n_status    = STS_EMPTY;
                            end else begin
                                n_state     = S_DUMP;
                                n_dump_left = r_count;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                // One entry per transfer; the row rotates the next one to the head
                if (w_out_free) begin
                    w_ctrl.op   = OP_ROTATE;
                    n_out_valid = 1'b1;
                    n_status    = STS_OK;
                    n_entry     = w_head;
                    n_last      = (r_dump_left == CW'(1));
                    n_dump_left = r_dump_left - 1'b1;
                    if (r_dump_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_cnt_out = (n_out_valid && !(r_out_valid && !o_rsp.ready))
                    ? w_cnt_ext[SLI_CNT_OUT_W-1:0] : r_cnt_out;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dump_left <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dump_left <= n_dump_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_entry   <= n_entry;
        r_cnt_out <= n_cnt_out;
        r_last    <= n_last;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_value = r_entry;
    assign o_rsp.entry_count = r_cnt_out;
    assign o_rsp.last        = r_last;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the sorted list store: random and directed requests.

module testbench;
    import sli_pkg::*;

    localparam int DEPTH = SLI_DEPTH;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic signed [SLI_VAL_W-1:0] VAL_MIN = {1'b1, {(SLI_VAL_W-1){1'b0}}};
    localparam logic signed [SLI_VAL_W-1:0] VAL_MAX = {1'b0, {(SLI_VAL_W-1){1'b1}}};
    localparam int RANDOM_ITEMS = 435;
    localparam int QUIET_TAIL = 50;
    localparam int HOLD_AT = 200;
    localparam int HOLD_CYCLES = 80;
    localparam int TIMEOUT_CYCLES = 600000;

    typedef struct {
        logic [1:0]                  action;
        logic signed [SLI_VAL_W-1:0] value;
    } t_req_item;

    typedef struct {
        t_status                     status;
        logic signed [SLI_VAL_W-1:0] entry_value;
        logic [SLI_CNT_OUT_W-1:0]    entry_count;
        logic                        last;
    } t_rsp_item;

    logic i_clk;
    logic i_rst_n;

    sli_req_if req_bus ();
    sli_rsp_if rsp_bus ();

    sorted_list_insert_delete i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Requests still to send, results still owed by the block
    t_req_item pending_reqs[$];
    t_rsp_item expected_rsps[$];
    logic signed [SLI_VAL_W-1:0] inserted_pool[$];

    // Shadow of the sorted store
    logic signed [SLI_VAL_W-1:0] list_mem [DEPTH];
    int list_len;

    int total_reqs;
    int accepted_cnt;
    int fail_cnt;
    logic quiet;
    int hold_left;
    logic hold_done;

    function automatic void push_result(input t_status st,
                                        input logic signed [SLI_VAL_W-1:0] v,
                                        input logic last);
        t_rsp_item r;
        r.status = st;
        r.entry_value = v;
        r.entry_count = SLI_CNT_OUT_W'(list_len);
        r.last = last;
        expected_rsps.push_back(r);
    endfunction

    // Apply one accepted request to the shadow list and queue its results
    function automatic void predict_list_op(input logic [1:0] action,
                                            input logic signed [SLI_VAL_W-1:0] value);
        int pos;
        if (action == ACT_INSERT) begin
            if (list_len >= DEPTH) begin
                push_result(STS_FULL, '0, 1'b1);
            end else begin
                // goes after equal entries, before the first greater one
                pos = list_len;
                for (int i = list_len - 1; i >= 0; i--) begin
                    if (list_mem[i] > value) pos = i;
                end
                for (int i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
                list_mem[pos] = value;
                list_len++;
                push_result(STS_OK, '0, 1'b1);
            end
        end else if (action == ACT_DELETE) begin
            pos = list_len;
            for (int i = list_len - 1; i >= 0; i--) begin
                if (list_mem[i] == value) pos = i;
            end
            if (pos == list_len) begin
                push_result(STS_NOT_FOUND, '0, 1'b1);
            end else begin
                for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
                list_len--;
                push_result(STS_OK, '0, 1'b1);
            end
        end else if (action == ACT_DUMP) begin
            if (list_len == 0) begin
                push_result(STS_EMPTY, '0, 1'b1);
            end else begin
                for (int i = 0; i < list_len; i++)
                    push_result(STS_OK, list_mem[i], (i + 1 == list_len));
            end
        end
    endfunction

    task automatic add_req(input logic [1:0] act, input logic signed [SLI_VAL_W-1:0] val);
        t_req_item it;
        it.action = act;
        it.value = val;
        pending_reqs.push_back(it);
        total_reqs++;
        if (act == ACT_INSERT) begin
            inserted_pool.push_back(val);
            if (inserted_pool.size() > 32) void'(inserted_pool.pop_front());
        end
    endtask

    // Mix of small values (duplicates), full-range values, extremes and old inserts
    function automatic logic signed [SLI_VAL_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0, 1: return $signed($urandom_range(0, 16)) - 8;
            2: return $urandom;
            3: begin
                case ($urandom_range(0, 5))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return VAL_MIN + 1;
                    3: return VAL_MAX - 1;
                    4: return -1;
                    default: return 0;
                endcase
            end
            default: begin
                if (inserted_pool.size() == 0) return $urandom;
                return inserted_pool[$urandom_range(0, inserted_pool.size() - 1)];
            end
        endcase
    endfunction

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Stimulus, reset and end of run
    initial begin
        int counted;
        int r;
        int ins_w;
        int phase_left;
        logic [1:0] act;

        i_rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.action = ACT_INSERT;
        req_bus.value = '0;
        rsp_bus.ready = 1'b0;
        list_len = 0;
        total_reqs = 0;
        accepted_cnt = 0;
        fail_cnt = 0;

        // directed: empty list, extremes, duplicates, misses, unused code, full list
        add_req(ACT_DUMP, 32'sd99);
        add_req(ACT_DELETE, 32'sd7);
        add_req(ACT_INSERT, VAL_MIN);
        add_req(ACT_INSERT, VAL_MAX);
        add_req(ACT_INSERT, 32'sd0);
        add_req(ACT_INSERT, -32'sd1);
        add_req(ACT_INSERT, 32'sd1);
        add_req(ACT_INSERT, 32'sd0);
        add_req(ACT_DUMP, '0);
        add_req(ACT_DELETE, 32'sd0);
        add_req(ACT_DELETE, 32'sd5);
        add_req(ACT_UNUSED, -32'sd1);
        for (int k = 0; k < 11; k++) add_req(ACT_INSERT, k * 3 - 15);
        add_req(ACT_INSERT, 32'sd42);
        add_req(ACT_DUMP, -32'sd1);
        add_req(ACT_DELETE, VAL_MIN);
        add_req(ACT_DELETE, VAL_MAX);

        // random: phases that lean toward filling or draining the list, or toward neither
        counted = 0;
        phase_left = 0;
        ins_w = 50;
        while (counted < RANDOM_ITEMS) begin
            if (phase_left == 0) begin
                phase_left = 40;
                case ($urandom_range(0, 2))
                    0: ins_w = 20;
                    1: ins_w = 50;
                    default: ins_w = 85;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < 6) act = ACT_DUMP;
            else if (r < 7) act = ACT_UNUSED;
            else if (r < 7 + ins_w * 93 / 100) act = ACT_INSERT;
            else act = ACT_DELETE;
            if (act == ACT_DELETE && inserted_pool.size() != 0 && $urandom_range(0, 9) < 7)
                add_req(act, inserted_pool[$urandom_range(0, inserted_pool.size() - 1)]);
            else
                add_req(act, pick_value());
            if (act != ACT_UNUSED) begin
                counted++;
                phase_left--;
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt != total_reqs) @(posedge i_clk);
        while (expected_rsps.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(20 * TIMEOUT_CYCLES);
        $display("Mismatches found");
        $finish;
    end

    // Long receiver hold-off, once, so the block backs up and stalls requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && !quiet && accepted_cnt >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Request driver
    int gap_left;
    int calm_tx;
    always @(posedge i_clk) begin
        logic offer;
        t_req_item nxt;
        int r;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            quiet <= 1'b0;
            gap_left = 0;
            calm_tx = 0;
        end else begin
            offer = req_bus.valid;
            // transfer taken: update the shadow list
            if (req_bus.valid && req_bus.ready) begin
                predict_list_op(req_bus.action, req_bus.value);
                accepted_cnt++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() != 0) begin
                    r = $urandom_range(0, 99);
                    if (!quiet && hold_left == 0 && calm_tx == 0 && r < 12) begin
                        gap_left = $urandom_range(1, 13) - 1;
                    end else begin
                        if (calm_tx > 0) calm_tx--;
                        else if (r >= 95) calm_tx = $urandom_range(10, 40);
                        nxt = pending_reqs.pop_front();
                        req_bus.action <= nxt.action;
                        req_bus.value <= nxt.value;
                        offer = 1'b1;
                    end
                end
            end
            req_bus.valid <= offer;
            quiet <= (pending_reqs.size() < QUIET_TAIL);
        end
    end

    // Result monitor and receiver stalls
    int stall_left;
    int calm_rx;
    always @(posedge i_clk) begin
        t_rsp_item exp_r;
        logic take;
        int r;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            stall_left = 0;
            calm_rx = 0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_rsps.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 50)
                        $display("%0t: unexpected result status=%0d value=%0d count=%0d last=%0d",
                                 $time, rsp_bus.status, rsp_bus.entry_value,
                                 rsp_bus.entry_count, rsp_bus.last);
                end else begin
                    exp_r = expected_rsps.pop_front();
                    if (rsp_bus.status !== exp_r.status
                        || rsp_bus.entry_value !== exp_r.entry_value
                        || rsp_bus.entry_count !== exp_r.entry_count
                        || rsp_bus.last !== exp_r.last) begin
                        fail_cnt++;
                        if (fail_cnt <= 50)
                            $display("%0t: expected status=%0d value=%0d count=%0d last=%0d, %s",
                                     $time, exp_r.status, exp_r.entry_value,
                                     exp_r.entry_count, exp_r.last,
                                     $sformatf("actual status=%0d value=%0d count=%0d last=%0d",
                                               rsp_bus.status, rsp_bus.entry_value,
                                               rsp_bus.entry_count, rsp_bus.last));
                    end
                end
            end
            // decide ready for the next edge
            if (hold_left != 0) begin
                take = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                take = 1'b0;
            end else if (quiet || calm_rx > 0) begin
                if (calm_rx > 0) calm_rx--;
                take = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                take = 1'b1;
                if (r < 10) begin
                    stall_left = $urandom_range(1, 13) - 1;
                    take = 1'b0;
                end else if (r < 12) begin
                    calm_rx = $urandom_range(20, 80);
                end
            end
            rsp_bus.ready <= take;
        end
    end

endmodule

// ===== files.f =====
rtl/sli_pkg.sv
rtl/sli_if.sv
rtl/sli_cell.sv
rtl/sli_chain.sv
rtl/sorted_list_insert_delete.sv
tb/testbench.sv
